### design/bru_pkg.sv
package bru_pkg;

    localparam int unsigned MODE_W = 5;
    localparam int unsigned DATA_W = 64;
    localparam int unsigned ADDR_W = 32;
    localparam int unsigned OFFS_W = 16;
    localparam int unsigned JIDX_W = 26;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_BEQ   = 5'd0;
    localparam logic [MODE_W-1:0] MODE_BEQL  = 5'd1;
    localparam logic [MODE_W-1:0] MODE_BNE   = 5'd2;
    localparam logic [MODE_W-1:0] MODE_BNEL  = 5'd3;
    localparam logic [MODE_W-1:0] MODE_BGEZ  = 5'd4;
    localparam logic [MODE_W-1:0] MODE_BGEZL = 5'd5;
    localparam logic [MODE_W-1:0] MODE_BGTZ  = 5'd6;
    localparam logic [MODE_W-1:0] MODE_BGTZL = 5'd7;
    localparam logic [MODE_W-1:0] MODE_BLEZ  = 5'd8;
    localparam logic [MODE_W-1:0] MODE_BLEZL = 5'd9;
    localparam logic [MODE_W-1:0] MODE_BLTZ  = 5'd10;
    localparam logic [MODE_W-1:0] MODE_BLTZL = 5'd11;
    localparam logic [MODE_W-1:0] MODE_BC1F  = 5'd12;
    localparam logic [MODE_W-1:0] MODE_BC1FL = 5'd13;
    localparam logic [MODE_W-1:0] MODE_BC1T  = 5'd14;
    localparam logic [MODE_W-1:0] MODE_BC1TL = 5'd15;
    localparam logic [MODE_W-1:0] MODE_J     = 5'd16;
    localparam logic [MODE_W-1:0] MODE_JR    = 5'd17;

    typedef struct packed {
        logic              taken;
        logic [ADDR_W-1:0] target;
        logic              nullify_next;
        logic              cop_unusable;
    } t_result;

    // pc + 4 + (sign-extended offset << 2), wraps mod 2^32
    function automatic logic [ADDR_W-1:0] branch_dest(
        input logic [ADDR_W-1:0] pc,
        input logic [OFFS_W-1:0] offs
    );
        logic [ADDR_W-1:0] disp;
        disp = {{(ADDR_W-OFFS_W-2){offs[OFFS_W-1]}}, offs, 2'b00};
        return pc + ADDR_W'(4) + disp;
    endfunction

endpackage

### design/branch_resolve_unit_top.sv
// branch resolve unit
// one command channel: drive start high for one cycle with the operands on
// i_mode .. i_cop1_usable; a beat is taken at every rising edge with start
// high and busy low. busy never rises, so a new branch can be issued every
// cycle.
// the result (o_taken, o_target, o_nullify_next, o_cop_unusable) appears for
// exactly one cycle with o_done high. the operand register loads at the
// command edge, and the compare / target adder feeds the result register
// behind it. throughput is one branch per cycle.
// o_target is zero whenever o_taken is low. unknown operation codes give an
// all-zero result.
// reset (i_rst_n low, synchronous) drops any command in flight; no o_done
// follows for it.
// the receiver cannot stall: it must take each result in the o_done cycle.
module branch_resolve_unit_top
    import bru_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [MODE_W-1:0]        i_mode,
    input  logic signed [DATA_W-1:0] i_rs_value,
    input  logic signed [DATA_W-1:0] i_rt_value,
    input  logic signed [OFFS_W-1:0] i_offset,
    input  logic [JIDX_W-1:0]        i_jump_index,
    input  logic [ADDR_W-1:0]        i_pc,
    input  logic                     i_fpu_cond,
    input  logic                     i_cop1_usable,
    output logic                     o_done,
    output logic                     o_taken,
    output logic [ADDR_W-1:0]        o_target,
    output logic                     o_nullify_next,
    output logic                     o_cop_unusable
);

    logic                     r_in_vld;
    logic [MODE_W-1:0]        r_mode;
    logic signed [DATA_W-1:0] r_rs;
    logic signed [DATA_W-1:0] r_rt;
    logic [OFFS_W-1:0]        r_offs;
    logic [JIDX_W-1:0]        r_jidx;
    logic [ADDR_W-1:0]        r_pc;
    logic                     r_fc;
    logic                     r_usable;

    logic                     r_out_vld;
    t_result                  r_res;
    t_result                  n_res;

    logic                     rs_neg;
    logic                     rs_zero;
    logic                     rs_eq_rt;
    logic                     is_cond;
    logic                     is_bc1;
    logic                     likely;
    logic                     cond;
    logic [ADDR_W-1:0]        pc_plus4;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= start && !busy;
            r_out_vld <= r_in_vld;
        end
        if (start && !busy) begin
            r_mode   <= i_mode;
            r_rs     <= i_rs_value;
            r_rt     <= i_rt_value;
            r_offs   <= i_offset;
            r_jidx   <= i_jump_index;
            r_pc     <= i_pc;
            r_fc     <= i_fpu_cond;
            r_usable <= i_cop1_usable;
        end
        r_res <= n_res;
    end

    assign rs_neg   = r_rs[DATA_W-1];
    assign rs_zero  = (r_rs == '0);
    assign rs_eq_rt = (r_rs == r_rt);
    assign pc_plus4 = r_pc + ADDR_W'(4);

    always_comb begin
        is_cond = 1'b1;
        is_bc1  = 1'b0;
        likely  = 1'b0;
        cond    = 1'b0;
        unique case (r_mode)
            MODE_BEQ:   cond = rs_eq_rt;
            MODE_BEQL:  begin cond = rs_eq_rt; likely = 1'b1; end
            MODE_BNE:   cond = !rs_eq_rt;
            MODE_BNEL:  begin cond = !rs_eq_rt; likely = 1'b1; end
            MODE_BGEZ:  cond = !rs_neg;
            MODE_BGEZL: begin cond = !rs_neg; likely = 1'b1; end
            MODE_BGTZ:  cond = !rs_neg && !rs_zero;
            MODE_BGTZL: begin cond = !rs_neg && !rs_zero; likely = 1'b1; end
            MODE_BLEZ:  cond = rs_neg || rs_zero;
            MODE_BLEZL: begin cond = rs_neg || rs_zero; likely = 1'b1; end
            MODE_BLTZ:  cond = rs_neg;
            MODE_BLTZL: begin cond = rs_neg; likely = 1'b1; end
            MODE_BC1F:  begin cond = !r_fc; is_bc1 = 1'b1; end
            MODE_BC1FL: begin cond = !r_fc; is_bc1 = 1'b1; likely = 1'b1; end
            MODE_BC1T:  begin cond = r_fc; is_bc1 = 1'b1; end
            MODE_BC1TL: begin cond = r_fc; is_bc1 = 1'b1; likely = 1'b1; end
            default:    is_cond = 1'b0;
        endcase
    end

    always_comb begin
        n_res = '0;
        if (is_cond) begin
            if (is_bc1 && !r_usable) begin
                n_res.cop_unusable = 1'b1;
            end else if (cond) begin
                n_res.taken  = 1'b1;
                n_res.target = branch_dest(r_pc, r_offs);
            end else begin
                n_res.nullify_next = likely;
            end
        end else if (r_mode == MODE_J) begin
            n_res.taken  = 1'b1;
            n_res.target = {pc_plus4[ADDR_W-1 -: 4], r_jidx, 2'b00};
        end else if (r_mode == MODE_JR) begin
            n_res.taken  = 1'b1;
            n_res.target = r_rs[ADDR_W-1:0];
        end
    end

    assign o_done         = r_out_vld;
    assign o_taken        = r_res.taken;
    assign o_target       = r_res.target;
    assign o_nullify_next = r_res.nullify_next;
    assign o_cop_unusable = r_res.cop_unusable;

    // every accepted beat yields one result strobe on o_done
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_done)
        else $error("result strobe missing after command");

    // no result without an earlier accepted command
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, 2))
        else $error("result strobe without command");

    a_taken_vs_null: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_taken && o_nullify_next))
        else $error("taken branch also nullifies delay slot");

    a_cop_unusable_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_cop_unusable) |-> (!o_taken && !o_nullify_next && o_target == '0))
        else $error("coprocessor unusable result has side effects");

    a_not_taken_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_taken) |-> (o_target == '0))
        else $error("target nonzero on not-taken branch");

endmodule
